// ----- design/tma_pkg.sv -----
// ----------------------------------------------------------------------------
// tma_pkg
// Shared types, widths and codes of the text metrics accumulator.
// ----------------------------------------------------------------------------
package tma_pkg;

  // Glyph table geometry
  localparam int GLYPH_CODES = 256;
  localparam int GLYPH_AW    = $clog2(GLYPH_CODES);

  // Field widths
  localparam int CODE_W  = 8;
  localparam int LEN16_W = 16;
  localparam int LEN32_W = 32;
  localparam int DEPTH_W = 17;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Input opcodes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_CHAR = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // Result kinds
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Register indexes
  localparam logic REG_LINE_PITCH = 1'b0;

  // Character codes with a meaning of their own
  localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_VTAB    = 8'd11;
  localparam logic [CODE_W-1:0] CODE_FFEED   = 8'd12;
  localparam logic [CODE_W-1:0] CODE_CR      = 8'd13;
  localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

  // One glyph table entry, 10.6 lengths
  typedef struct packed {
    logic        [LEN16_W-1:0] advance;
    logic        [LEN16_W-1:0] height;
    logic signed [LEN16_W-1:0] bearing;
  } glyph_t;

  // Whitespace other than newline
  function automatic logic is_blank(input logic [CODE_W-1:0] c);
    return (c == CODE_TAB) || (c == CODE_VTAB) || (c == CODE_FFEED) ||
           (c == CODE_CR) || (c == CODE_SPACE);
  endfunction

endpackage

// ----- design/tma_in_if.sv -----
// ----------------------------------------------------------------------------
// tma_in_if
// Input channel: glyph loads, text characters and end markers.
// ----------------------------------------------------------------------------
interface tma_in_if import tma_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [1:0]         opcode;
  logic        [CODE_W-1:0]  char_code;
  logic        [LEN16_W-1:0] glyph_advance;
  logic        [LEN16_W-1:0] glyph_height;
  logic signed [LEN16_W-1:0] glyph_bearing_y;

  modport source (output valid, opcode, char_code, glyph_advance, glyph_height,
                  glyph_bearing_y, input ready);
  modport sink   (input valid, opcode, char_code, glyph_advance, glyph_height,
                  glyph_bearing_y, output ready);
endinterface

// ----- design/tma_out_if.sv -----
// ----------------------------------------------------------------------------
// tma_out_if
// Result channel: finished line widths and final text metrics.
// ----------------------------------------------------------------------------
interface tma_out_if import tma_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [LEN32_W-1:0] line_width;
  logic [LEN32_W-1:0] max_line_width;
  logic [LEN16_W-1:0] line_break_count;
  logic [LEN16_W-1:0] drawable_count;
  logic [LEN16_W-1:0] first_line_height;
  logic [LEN32_W-1:0] total_height;
  logic [LEN32_W-1:0] total_with_bottom;

  modport source (output valid, kind, line_width, max_line_width, line_break_count,
                  drawable_count, first_line_height, total_height, total_with_bottom,
                  input ready);
  modport sink   (input valid, kind, line_width, max_line_width, line_break_count,
                  drawable_count, first_line_height, total_height, total_with_bottom,
                  output ready);
endinterface

// ----- design/text_metrics_accumulator.sv -----
// A result passes from the update stage through the totals stage to the output register.
// Throughput: one item per cycle unless the update stage blocks; each character
// makes one glyph table read at transfer, then its line update; a load one write.
// Reset clears line_pitch, the running line metrics and all pipeline valids at once;
// the glyph table is not cleared and holds unknown data until loaded.
// ----------------------------------------------------------------------------
// text_metrics_accumulator
// Glyph table memory with a line metrics update stage, a totals stage and an
// output register.
// ----------------------------------------------------------------------------
module text_metrics_accumulator import tma_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  tma_in_if.sink             in_ch,
  tma_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Configuration
  logic [LEN16_W-1:0] line_pitch;

  // Glyph table
  glyph_t glyph_mem [GLYPH_CODES];
  glyph_t glyph_rd;

  // Running state
  logic [LEN32_W-1:0] run_width;
  logic [DEPTH_W-1:0] line_depth;
  logic [LEN32_W-1:0] widest;
  logic [LEN16_W-1:0] break_cnt;
  logic [LEN16_W-1:0] draw_cnt;
  logic [LEN16_W-1:0] top_height;

  // Update stage
  logic              s1_valid;
  logic [1:0]        s1_op;
  logic [CODE_W-1:0] s1_code;
  logic              s1_in_range;

  // Totals stage
  logic               s2_valid;
  logic               s2_kind;
  logic [LEN32_W-1:0] s2_width;
  logic [LEN32_W-1:0] s2_max;
  logic [LEN16_W-1:0] s2_breaks;
  logic [LEN16_W-1:0] s2_draw;
  logic [LEN16_W-1:0] s2_top;
  logic [LEN32_W-1:0] s2_prod;
  logic [DEPTH_W-1:0] s2_depth;

  // Output register
  logic               out_valid;
  logic               out_kind;
  logic [LEN32_W-1:0] out_width;
  logic [LEN32_W-1:0] out_max;
  logic [LEN16_W-1:0] out_breaks;
  logic [LEN16_W-1:0] out_draw;
  logic [LEN16_W-1:0] out_top;
  logic [LEN32_W-1:0] out_total;
  logic [LEN32_W-1:0] out_bottom;

  // Handshake and flow control
  logic in_xfer;
  logic in_range;
  logic out_free;
  logic s2_move;
  logic s1_newline;
  logic s1_end;
  logic s1_char;
  logic s1_has_res;
  logic s1_fire;
  logic cfg_wr;

  // Update stage datapath
  glyph_t                    glyph;
  logic [LEN32_W:0]          width_sum;
  logic [LEN32_W-1:0]        width_next;
  logic signed [DEPTH_W:0]   depth_diff;
  logic [DEPTH_W-1:0]        depth_next;
  logic [LEN16_W-1:0]        draw_next;
  logic [LEN16_W-1:0]        top_next;
  logic [LEN16_W-1:0]        break_next;
  logic [LEN32_W-1:0]        widest_next;
  logic [LEN32_W-1:0]        prod_next;

  // Totals stage datapath
  logic [LEN32_W+1:0] total_sum;
  logic [LEN32_W+1:0] bottom_sum;
  logic [LEN32_W-1:0] total_next;
  logic [LEN32_W-1:0] bottom_next;

  // Flow control: the update stage blocks only when it holds a result that the
  // totals stage cannot take
  assign in_range   = {1'b0, in_ch.char_code} < (CODE_W+1)'(GLYPH_CODES);
  assign out_free   = !out_valid || out_ch.ready;
  assign s2_move    = !s2_valid || out_free;
  assign s1_char    = s1_valid && (s1_op == OP_CHAR);
  assign s1_newline = s1_char && (s1_code == CODE_NEWLINE);
  assign s1_end     = s1_valid && (s1_op == OP_END);
  assign s1_has_res = s1_newline || s1_end;
  assign s1_fire    = s1_valid && (s2_move || !s1_has_res);
  assign in_ch.ready = !s1_valid || s1_fire;
  assign in_xfer    = in_ch.valid && in_ch.ready;

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LINE_PITCH);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LINE_PITCH) ? PDATA_W'(line_pitch) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pitch <= '0;
    end else if (cfg_wr) begin
      line_pitch <= pwdata[LEN16_W-1:0];
    end
  end

  // Glyph table: write on load transfer, read on character transfer
  always_ff @(posedge clk) begin
    if (in_xfer && (in_ch.opcode == OP_LOAD) && in_range) begin
      glyph_mem[in_ch.char_code[GLYPH_AW-1:0]] <= '{advance: in_ch.glyph_advance,
                                                   height:  in_ch.glyph_height,
                                                   bearing: in_ch.glyph_bearing_y};
    end
    if (in_xfer && (in_ch.opcode == OP_CHAR) && in_range) begin
      glyph_rd <= glyph_mem[in_ch.char_code[GLYPH_AW-1:0]];
    end
  end

  // Capture the item into the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op       <= in_ch.opcode;
      s1_code     <= in_ch.char_code;
      s1_in_range <= in_range;
    end
  end

  // Line update for one character
  always_comb begin
    glyph      = s1_in_range ? glyph_rd : '0;
    width_sum  = {1'b0, run_width} + (LEN32_W+1)'(glyph.advance);
    width_next = width_sum[LEN32_W] ? '1 : width_sum[LEN32_W-1:0];
    depth_diff = signed'((DEPTH_W+1)'(glyph.height)) - (DEPTH_W+1)'(glyph.bearing);
    depth_next = line_depth;
    if (!depth_diff[DEPTH_W] && (depth_diff[DEPTH_W-1:0] > line_depth)) begin
      depth_next = depth_diff[DEPTH_W-1:0];
    end
    draw_next = draw_cnt;
    if (!is_blank(s1_code) && (draw_cnt != '1)) begin
      draw_next = draw_cnt + 1'b1;
    end
    top_next = top_height;
    if ((break_cnt == '0) && (glyph.height > top_height)) begin
      top_next = glyph.height;
    end
    break_next  = (break_cnt == '1) ? break_cnt : break_cnt + 1'b1;
    widest_next = (run_width > widest) ? run_width : widest;
    prod_next   = LEN32_W'(line_pitch) * LEN32_W'(break_cnt);
  end

  // Commit the running state
  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_end)) begin
      run_width  <= '0;
      line_depth <= '0;
      widest     <= '0;
      break_cnt  <= '0;
      draw_cnt   <= '0;
      top_height <= '0;
    end else if (s1_fire && s1_newline) begin
      break_cnt  <= break_next;
      widest     <= widest_next;
      run_width  <= '0;
      line_depth <= '0;
    end else if (s1_fire && s1_char) begin
      run_width  <= width_next;
      line_depth <= depth_next;
      draw_cnt   <= draw_next;
      top_height <= top_next;
    end
  end

  // Snapshot a result into the totals stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_move) begin
      s2_valid <= s1_fire && s1_has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s1_fire && s1_has_res) begin
      s2_kind   <= s1_end ? KIND_END : KIND_LINE;
      s2_width  <= run_width;
      s2_max    <= widest_next;
      s2_breaks <= s1_end ? break_cnt : break_next;
      s2_draw   <= draw_cnt;
      s2_top    <= top_height;
      s2_prod   <= prod_next;
      s2_depth  <= line_depth;
    end
  end

  // Saturating totals, zero for line results
  always_comb begin
    total_sum   = (LEN32_W+2)'(s2_prod) + (LEN32_W+2)'(s2_top);
    bottom_sum  = total_sum + (LEN32_W+2)'(s2_depth);
    total_next  = (total_sum[LEN32_W+1:LEN32_W] != '0) ? '1 : total_sum[LEN32_W-1:0];
    bottom_next = (bottom_sum[LEN32_W+1:LEN32_W] != '0) ? '1 : bottom_sum[LEN32_W-1:0];
    if (s2_kind == KIND_LINE) begin
      total_next  = '0;
      bottom_next = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      out_kind   <= s2_kind;
      out_width  <= s2_width;
      out_max    <= s2_max;
      out_breaks <= s2_breaks;
      out_draw   <= s2_draw;
      out_top    <= s2_top;
      out_total  <= total_next;
      out_bottom <= bottom_next;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.kind              = out_kind;
  assign out_ch.line_width        = out_width;
  assign out_ch.max_line_width    = out_max;
  assign out_ch.line_break_count  = out_breaks;
  assign out_ch.drawable_count    = out_draw;
  assign out_ch.first_line_height = out_top;
  assign out_ch.total_height      = out_total;
  assign out_ch.total_with_bottom = out_bottom;

  // An end transfer leaves the running state cleared
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_end |=> (run_width == '0) && (break_cnt == '0) && (widest == '0))
    else $error("running state not cleared after end");

  // A newline starts an empty line
  a_newline_resets_line: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_newline |=> (run_width == '0) && (line_depth == '0))
    else $error("line not reset after newline");

  // The newline count only falls on an end
  a_breaks_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(s1_fire && s1_end) |=> break_cnt >= $past(break_cnt))
    else $error("newline count decreased");

  // First-line height is frozen once a newline was seen
  a_top_frozen: assert property (@(posedge clk) disable iff (rst)
    (break_cnt != '0) && !(s1_fire && s1_end) |=> $stable(top_height))
    else $error("first-line height changed after first line");

  // Line results carry no totals
  a_line_totals_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_LINE) |-> (out_total == '0) && (out_bottom == '0))
    else $error("line result with nonzero totals");

endmodule

// ----- tb/tma_metrics_checker.sv -----
// ----------------------------------------------------------------------------
// tma_metrics_checker
// Watches the glyph/text channel, the result channel and the register port of
// the text metrics accumulator. Keeps its own copy of the glyph table and the
// running line metrics, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tma_metrics_checker import tma_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  tma_in_if                  in_ch,
  tma_out_if                 out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending,
  output int                 line_results,
  output int                 end_results
);

  localparam logic [PADDR_W-1:0] PITCH_ADDR = PADDR_W'(REG_LINE_PITCH) << 2;

  typedef struct packed {
    logic               kind;
    logic [LEN32_W-1:0] line_width;
    logic [LEN32_W-1:0] max_line_width;
    logic [LEN16_W-1:0] line_break_count;
    logic [LEN16_W-1:0] drawable_count;
    logic [LEN16_W-1:0] first_line_height;
    logic [LEN32_W-1:0] total_height;
    logic [LEN32_W-1:0] total_with_bottom;
  } metrics_t;

  // Shadow of the block: glyph table, pitch register and running line metrics
  glyph_t             glyph_mem [GLYPH_CODES];
  logic [LEN16_W-1:0] pitch;
  logic [LEN32_W-1:0] width_acc;
  logic [LEN32_W-1:0] widest;
  logic [DEPTH_W-1:0] depth;
  logic [LEN16_W-1:0] breaks;
  logic [LEN16_W-1:0] drawables;
  logic [LEN16_W-1:0] top_height;
  metrics_t           metrics_q [$];

  function automatic logic [LEN32_W-1:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'hFFFF_FFFF) ? '1 : s[LEN32_W-1:0];
  endfunction

  function automatic logic [LEN16_W-1:0] bump16(input logic [LEN16_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic bit is_space(input logic [CODE_W-1:0] c);
    case (c)
      CODE_TAB, CODE_VTAB, CODE_FFEED, CODE_CR, CODE_SPACE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic flag(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string field, input logic [LEN32_W-1:0] got,
                             input logic [LEN32_W-1:0] want);
    if (got !== want) flag($sformatf("%s got %0h, want %0h", field, got, want));
  endtask

  // Advance the shadow state by one accepted item and queue any result
  task automatic apply_item(input logic [1:0] op, input logic [CODE_W-1:0] code,
                            input logic [LEN16_W-1:0] adv, input logic [LEN16_W-1:0] hgt,
                            input logic [LEN16_W-1:0] bear);
    glyph_t                    g;
    logic signed [DEPTH_W:0]   rise;
    logic [LEN32_W-1:0]        wmax;
    logic [LEN32_W-1:0]        total;
    metrics_t                  res;
    case (op)
      OP_LOAD: begin
        if (int'(code) < GLYPH_CODES) glyph_mem[code] = '{advance: adv, height: hgt, bearing: bear};
      end
      OP_CHAR: begin
        if (code == CODE_NEWLINE) begin
          breaks = bump16(breaks);
          if (width_acc > widest) widest = width_acc;
          res = '{kind: KIND_LINE, line_width: width_acc, max_line_width: widest,
                  line_break_count: breaks, drawable_count: drawables,
                  first_line_height: top_height, total_height: '0,
                  total_with_bottom: '0};
          metrics_q = {metrics_q, res};
          width_acc = '0;
          depth     = '0;
        end else begin
          g = (int'(code) < GLYPH_CODES) ? glyph_mem[code] : '0;
          width_acc = sat_sum(64'(width_acc), 64'(g.advance));
          // depth below baseline is height minus bearing, floored at zero
          rise = $signed({2'b00, g.height}) - $signed({{2{g.bearing[LEN16_W-1]}}, g.bearing});
          if (rise > 0 && rise[DEPTH_W-1:0] > depth) depth = rise[DEPTH_W-1:0];
          if (!is_space(code)) drawables = bump16(drawables);
          if (breaks == '0 && g.height > top_height) top_height = g.height;
        end
      end
      OP_END: begin
        wmax  = (width_acc > widest) ? width_acc : widest;
        total = sat_sum(64'(pitch) * 64'(breaks), 64'(top_height));
        res = '{kind: KIND_END, line_width: width_acc, max_line_width: wmax,
                line_break_count: breaks, drawable_count: drawables,
                first_line_height: top_height, total_height: total,
                total_with_bottom: sat_sum(64'(total), 64'(depth))};
        metrics_q = {metrics_q, res};
        width_acc  = '0;
        depth      = '0;
        widest     = '0;
        breaks     = '0;
        drawables  = '0;
        top_height = '0;
      end
      default: ;
    endcase
  endtask

  // Compare one accepted result against the oldest prediction
  task automatic compare_result();
    metrics_t want;
    if (metrics_q.size() == 0) begin
      flag($sformatf("result of kind %0b with nothing predicted", out_ch.kind));
    end else begin
      want = metrics_q.pop_front();
      check_field("kind", 32'(out_ch.kind), 32'(want.kind));
      check_field("line_width", out_ch.line_width, want.line_width);
      check_field("max_line_width", out_ch.max_line_width, want.max_line_width);
      check_field("line_break_count", 32'(out_ch.line_break_count), 32'(want.line_break_count));
      check_field("drawable_count", 32'(out_ch.drawable_count), 32'(want.drawable_count));
      check_field("first_line_height", 32'(out_ch.first_line_height),
                  32'(want.first_line_height));
      check_field("total_height", out_ch.total_height, want.total_height);
      check_field("total_with_bottom", out_ch.total_with_bottom, want.total_with_bottom);
      if (want.kind == KIND_END) end_results++;
      else line_results++;
    end
  endtask

  // Track register writes, results and accepted items at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      pitch      = '0;
      width_acc  = '0;
      depth      = '0;
      widest     = '0;
      breaks     = '0;
      drawables  = '0;
      top_height = '0;
      metrics_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == PITCH_ADDR)
        pitch = pwdata[LEN16_W-1:0];
      if (out_ch.valid && out_ch.ready) compare_result();
      if (in_ch.valid && in_ch.ready)
        apply_item(in_ch.opcode, in_ch.char_code, in_ch.glyph_advance, in_ch.glyph_height,
                   in_ch.glyph_bearing_y);
      pending <= metrics_q.size();
    end
  end

endmodule

// ----- tb/tb_text_metrics_accumulator.sv -----
// ----------------------------------------------------------------------------
// tb_text_metrics_accumulator
// Drives glyph loads, text and end markers into the accumulator with random
// gaps and result stalls, and writes the line pitch between phases, from zero
// to full scale. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_text_metrics_accumulator;
  import tma_pkg::*;

  localparam logic [1:0]         OP_UNUSED     = 2'd3;
  localparam logic [PADDR_W-1:0] PITCH_ADDR    = PADDR_W'(REG_LINE_PITCH) << 2;
  localparam int                 PHASES        = 6;
  localparam int                 PHASE_ITEMS   = 275;
  localparam int                 STALL_LIMIT   = 1000;
  localparam int                 SETTLE_CYCLES = 4;
  localparam int                 DRAIN_CYCLES  = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tma_in_if  in_ch ();
  tma_out_if out_ch ();

  int fail_count;
  int pending;
  int line_results;
  int end_results;

  bit in_steady;
  bit out_steady;
  int loads_sent;
  int chars_sent;
  int ends_sent;
  int ignored_sent;
  int pitch_writes;
  int stalled_cycles;

  bit                glyph_loaded [GLYPH_CODES];
  logic [CODE_W-1:0] loaded_codes [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_metrics_accumulator DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tma_metrics_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .line_results (line_results),
    .end_results  (end_results)
  );

  function automatic int unsigned idle_cycles(input bit steady);
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // Lengths lean toward the field extremes
  function automatic logic [LEN16_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return LEN16_W'($urandom);
    endcase
  endfunction

  // Text draws from loaded codes, with extra weight on whitespace
  function automatic logic [CODE_W-1:0] pick_text_code();
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 4))
        0: return CODE_TAB;
        1: return CODE_VTAB;
        2: return CODE_FFEED;
        3: return CODE_CR;
        default: return CODE_SPACE;
      endcase
    end
    return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input logic [1:0] op, input logic [CODE_W-1:0] code,
                           input logic [LEN16_W-1:0] adv, input logic [LEN16_W-1:0] hgt,
                           input logic [LEN16_W-1:0] bear);
    int unsigned gap;
    gap = idle_cycles(in_steady);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= op;
    in_ch.char_code       <= code;
    in_ch.glyph_advance   <= adv;
    in_ch.glyph_height    <= hgt;
    in_ch.glyph_bearing_y <= bear;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic load_glyph(input logic [CODE_W-1:0] code, input logic [LEN16_W-1:0] adv,
                            input logic [LEN16_W-1:0] hgt, input logic [LEN16_W-1:0] bear);
    send_item(OP_LOAD, code, adv, hgt, bear);
    if (!glyph_loaded[code]) begin
      glyph_loaded[code] = 1'b1;
      loaded_codes = {loaded_codes, code};
    end
    loads_sent++;
  endtask

  // Glyph fields of text and end items carry noise that the block must ignore
  task automatic send_char(input logic [CODE_W-1:0] code);
    send_item(OP_CHAR, code, LEN16_W'($urandom), LEN16_W'($urandom), LEN16_W'($urandom));
    chars_sent++;
  endtask

  task automatic send_end();
    send_item(OP_END, CODE_W'($urandom), LEN16_W'($urandom), LEN16_W'($urandom),
              LEN16_W'($urandom));
    ends_sent++;
  endtask

  task automatic send_unused();
    send_item(OP_UNUSED, CODE_W'($urandom), LEN16_W'($urandom), LEN16_W'($urandom),
              LEN16_W'($urandom));
    ignored_sent++;
  endtask

  // Drop valid, wait out every predicted result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then access cycle held until pready
  task automatic write_pitch(input logic [LEN16_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PITCH_ADDR;
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pitch_writes++;
  endtask

  // Result side: random stall before each transfer, with steady stretches
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    out_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      if (taken % 24 == 0) out_steady = ($urandom_range(0, 3) == 0);
      stall = idle_cycles(out_steady);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("text_metrics_accumulator regression: fail");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    int                 counted;
    int unsigned        pick;
    logic [LEN16_W-1:0] setting;
    in_ch.valid           = 1'b0;
    in_ch.opcode          = OP_LOAD;
    in_ch.char_code       = '0;
    in_ch.glyph_advance   = '0;
    in_ch.glyph_height    = '0;
    in_ch.glyph_bearing_y = '0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed: table extremes, whitespace, empty text, empty line, ignored opcode
    write_pitch(16'h0140);
    load_glyph(CODE_NEWLINE, '0, '0, '0);
    load_glyph(8'h00, '0, '0, '0);
    load_glyph(8'hFF, '1, '1, 16'h8000);
    // bearing above the height: depth stays floored at zero
    load_glyph(8'h41, 16'h0280, 16'h0300, 16'h7FFF);
    load_glyph(CODE_TAB, 16'h0100, 16'h0040, 16'hFFC0);
    load_glyph(CODE_VTAB, 16'h0010, 16'h0020, 16'h0010);
    load_glyph(CODE_FFEED, 16'h0020, 16'h0000, 16'h0000);
    load_glyph(CODE_CR, 16'h0000, 16'h0080, 16'hFF00);
    load_glyph(CODE_SPACE, 16'h0100, 16'h0000, 16'h0000);
    send_end();
    send_char(8'h41);
    send_char(CODE_SPACE);
    send_char(CODE_TAB);
    send_char(8'h00);
    send_char(CODE_NEWLINE);
    // a tall glyph after the first line leaves the first-line height alone
    send_char(CODE_VTAB);
    send_char(CODE_FFEED);
    send_char(CODE_CR);
    send_char(8'hFF);
    send_char(CODE_NEWLINE);
    send_char(CODE_NEWLINE);
    send_unused();
    send_char(8'h41);
    send_end();
    settle();

    // Random phases, each under its own line pitch
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: setting = '0;
        1: setting = '1;
        2: setting = 16'h0001;
        default: setting = LEN16_W'($urandom);
      endcase
      write_pitch(setting);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if (counted % 50 == 0) in_steady = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          load_glyph(CODE_W'($urandom_range(0, GLYPH_CODES - 1)), pick_len(), pick_len(),
                     pick_len());
        end else if (pick < 10) begin
          send_unused();
          continue;
        end else if (pick < 14) begin
          send_end();
        end else if (pick < 26) begin
          send_char(CODE_NEWLINE);
        end else begin
          send_char(pick_text_code());
        end
        counted++;
      end
      settle();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d glyph loads, %0d characters, %0d end markers, %0d ignored items",
             loads_sent, chars_sent, ends_sent, ignored_sent);
    $display("checked %0d line results and %0d end results over %0d pitch writes",
             line_results, end_results, pitch_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("text_metrics_accumulator regression: pass");
    end else begin
      $display("text_metrics_accumulator regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tma_pkg.sv
design/tma_in_if.sv
design/tma_out_if.sv
design/text_metrics_accumulator.sv
tb/tma_metrics_checker.sv
tb/tb_text_metrics_accumulator.sv
